>>> src/hc_pkg.sv
// Shared types, constants and modulo-26 helpers for the 3x3 Hill cipher block.
// No dependencies; used by every module in this folder.
`default_nettype none

package hc_pkg;

  localparam int MODV       = 26;
  localparam int RECIP      = 78;
  localparam int RECIP_SH   = 11;
  localparam int BLOCK_LEN_DEF = 3;
  localparam int KEY_LAT    = 7;
  localparam int LANE_LAT   = 2;

  localparam logic [14:0] KEY_ROW_0_RST = 15'd1;
  localparam logic [14:0] KEY_ROW_1_RST = 15'd32;
  localparam logic [14:0] KEY_ROW_2_RST = 15'd1024;

  typedef logic [4:0]  ent_t;
  typedef ent_t [2:0]  vec_t;
  typedef vec_t [2:0]  mat_t;
  typedef logic [14:0] row_t;

  typedef enum logic [1:0] {
    REG_KEY_ROW_0,
    REG_KEY_ROW_1,
    REG_KEY_ROW_2
  } cfg_reg_t;

  typedef struct packed {
    mat_t key;
    mat_t inv;
    logic unit;
  } key_info_t;

  function automatic ent_t red5(input ent_t x);
    red5 = (x >= ent_t'(MODV)) ? ent_t'(x - ent_t'(MODV)) : x;
  endfunction

  // reciprocal estimate never exceeds the true quotient, so one correction
  function automatic ent_t mod26(input logic [10:0] x);
    logic [17:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = {7'd0, x} * 18'(RECIP);
    q = prod[17:RECIP_SH];
    r = x - ({4'd0, q} * 11'(MODV));
    if (r >= 11'(MODV)) begin
      r = r - 11'(MODV);
    end
    mod26 = r[4:0];
  endfunction

  function automatic ent_t unit_inv(input ent_t d);
    case (d)
      5'd1:    unit_inv = 5'd1;
      5'd3:    unit_inv = 5'd9;
      5'd5:    unit_inv = 5'd21;
      5'd7:    unit_inv = 5'd15;
      5'd9:    unit_inv = 5'd3;
      5'd11:   unit_inv = 5'd19;
      5'd15:   unit_inv = 5'd7;
      5'd17:   unit_inv = 5'd23;
      5'd19:   unit_inv = 5'd11;
      5'd21:   unit_inv = 5'd5;
      5'd23:   unit_inv = 5'd17;
      5'd25:   unit_inv = 5'd25;
      default: unit_inv = 5'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> src/hill_cipher_3x3.sv
// Top level of the 3x3 Hill cipher: key registers, item pipeline, lanes, merge.
// Depends on hc_pkg, hc_keyinv and hc_lane.
//
// Takes one three-letter word per cycle and returns one result word per cycle
// unless a waiting result is held by out_stall. Each word passes through letter
// registers that run alongside the key inverse pipeline (seven register stages:
// key reduction, adjugate products, adjugate, determinant products, unit lookup,
// scaled products, reduction), then two stages in its row lane and the output
// register. The key inverse is derived continuously from the key registers, so a
// word may follow a key write at once.
// Decrypting with a key whose determinant is not a unit modulo 26 gives zero
// letters with out_key_error set. out_stall holds all but the key inverse pipeline.
`default_nettype none

module hill_cipher_3x3 import hc_pkg::*; #(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [4:0]  in_letter_0,
  input  wire logic [4:0]  in_letter_1,
  input  wire logic [4:0]  in_letter_2,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_0,
  output logic [4:0]       out_1,
  output logic [4:0]       out_2,
  output logic             out_key_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam int NUSE  = (BLOCK_LEN >= 3) ? 3 : 2;
  localparam int DEPTH = KEY_LAT + LANE_LAT;

  row_t             key_row_r [3];
  key_info_t        kinfo;
  logic             advance;
  logic             in_accept;
  vec_t             vec_in;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] op_r;
  vec_t             vec_r [KEY_LAT];
  ent_t             lane_res [3];
  ent_t             out_nxt [3];
  logic             err_nxt;
  logic             out_valid_r;
  ent_t             out_r [3];
  logic             key_error_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_row_r[0] <= KEY_ROW_0_RST;
      key_row_r[1] <= KEY_ROW_1_RST;
      key_row_r[2] <= KEY_ROW_2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_ROW_0: key_row_r[0] <= cfg_data;
        REG_KEY_ROW_1: key_row_r[1] <= cfg_data;
        REG_KEY_ROW_2: key_row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  hc_keyinv #(.BLOCK_LEN(BLOCK_LEN)) u_keyinv (
    .clk      (clk),
    .key_rows (key_row_r),
    .kinfo    (kinfo)
  );

  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    vec_in[0] = red5(in_letter_0);
    vec_in[1] = red5(in_letter_1);
    vec_in[2] = (NUSE == 3) ? red5(in_letter_2) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_accept};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op_r     <= {op_r[DEPTH-2:0], in_op};
      vec_r[0] <= vec_in;
      for (int k = 1; k < KEY_LAT; k++) begin
        vec_r[k] <= vec_r[k-1];
      end
      out_r       <= out_nxt;
      key_error_r <= err_nxt;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    hc_lane u_lane (
      .clk (clk),
      .en  (advance),
      .row (op_r[KEY_LAT-1] ? kinfo.inv[i] : kinfo.key[i]),
      .vec (vec_r[KEY_LAT-1]),
      .res (lane_res[i])
    );
  end

  // merge: zero all rows on a singular decrypt, and rows past the block length
  always_comb begin
    err_nxt = op_r[DEPTH-1] && !kinfo.unit;
    for (int i = 0; i < 3; i++) begin
      out_nxt[i] = (err_nxt || i >= NUSE) ? '0 : lane_res[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_0         = out_r[0];
  assign out_1         = out_r[1];
  assign out_2         = out_r[2];
  assign out_key_error = key_error_r;

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_error) |-> (out_0 == '0 && out_1 == '0 && out_2 == '0))
    else $error("key error word carries nonzero letters");

  a_enc_no_err : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DEPTH-1] && advance && !op_r[DEPTH-1]) |=> !out_key_error)
    else $error("key error raised on encrypt");

  a_letter_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_0 < 5'd26 && out_1 < 5'd26 && out_2 < 5'd26))
    else $error("result letter out of range");

endmodule

`default_nettype wire

>>> src/hc_keyinv.sv
// Key reduction and modular inverse pipeline: adjugate, determinant, unit lookup.
// Depends on hc_pkg. Free-running; output settles once a key change has passed every stage.
`default_nettype none

module hc_keyinv import hc_pkg::*; #(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic      clk,
  input  wire row_t      key_rows [3],
  output key_info_t      kinfo
);

  localparam int NUSE = (BLOCK_LEN >= 3) ? 3 : 2;

  mat_t       m_r;
  logic [9:0] p_nxt [3][3];
  logic [9:0] q_nxt [3][3];
  logic [9:0] p_r   [3][3];
  logic [9:0] q_r   [3][3];
  mat_t       adj_r;
  logic [9:0] dp_r  [3];
  ent_t       dinv_r;
  logic [9:0] ip_r  [3][3];
  mat_t       inv_r;

  // adj[i][j] = cof[j][i] = p - q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (NUSE == 3) begin
          p_nxt[i][j] = {5'd0, m_r[(j+1)%3][(i+1)%3]} * {5'd0, m_r[(j+2)%3][(i+2)%3]};
          q_nxt[i][j] = {5'd0, m_r[(j+1)%3][(i+2)%3]} * {5'd0, m_r[(j+2)%3][(i+1)%3]};
        end else begin
          p_nxt[i][j] = '0;
          q_nxt[i][j] = '0;
        end
      end
    end
    if (NUSE == 2) begin
      p_nxt[0][0] = {5'd0, m_r[1][1]};
      q_nxt[0][1] = {5'd0, m_r[0][1]};
      q_nxt[1][0] = {5'd0, m_r[1][0]};
      p_nxt[1][1] = {5'd0, m_r[0][0]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_r[i][j]   <= red5(key_rows[i][5*j +: 5]);
        p_r[i][j]   <= p_nxt[i][j];
        q_r[i][j]   <= q_nxt[i][j];
        adj_r[i][j] <= mod26({1'b0, p_r[i][j]} + 11'(MODV * MODV) - {1'b0, q_r[i][j]});
        ip_r[i][j]  <= {5'd0, adj_r[i][j]} * {5'd0, dinv_r};
        inv_r[i][j] <= mod26({1'b0, ip_r[i][j]});
      end
      dp_r[i] <= {5'd0, m_r[0][i]} * {5'd0, adj_r[i][0]};
    end
    dinv_r <= unit_inv(mod26({1'b0, dp_r[0]} + {1'b0, dp_r[1]} + {1'b0, dp_r[2]}));
  end

  assign kinfo.key  = m_r;
  assign kinfo.inv  = inv_r;
  assign kinfo.unit = (dinv_r != '0);

endmodule

`default_nettype wire

>>> src/hc_lane.sv
// One output row: dot product of a matrix row with the letter vector, modulo 26.
// Depends on hc_pkg. Two register stages, advanced by en.
`default_nettype none

module hc_lane import hc_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire vec_t row,
  input  wire vec_t vec,
  output ent_t      res
);

  logic [9:0] prod_r [3];
  ent_t       res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= {5'd0, row[k]} * {5'd0, vec[k]};
      end
      res_r <= mod26({1'b0, prod_r[0]} + {1'b0, prod_r[1]} + {1'b0, prod_r[2]});
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire
